// ===== sv/bsnp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsnp_pkg
// Shared types and constants of the beacon scan nearest picker: character
// codes, field widths, parser phases, register indexes and the result record.
// ----------------------------------------------------------------------------
package bsnp_pkg;

    // Field and counter widths
    localparam int BYTE_W      = 8;
    localparam int NUM_W       = 16;
    localparam int CNT_W       = 4;
    localparam int GROUP_CFG_W = 14;
    localparam int LOSS_CFG_W  = 10;
    localparam int CFG_DATA_W  = 14;

    // Default record layout
    localparam int PREFIX_LEN_DEF   = 8;
    localparam int ID_DIGITS_DEF    = 3;
    localparam int GROUP_DIGITS_DEF = 4;
    localparam int LOSS_DIGITS_DEF  = 3;

    // Character codes of the scan reply
    localparam logic [BYTE_W-1:0] CH_COLON = 8'd58;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_END   = 8'd69;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'd45;

    // Colons to pass over in a record with an all-zero prefix
    localparam logic [CNT_W-1:0] SKIP_COLONS = 4'd4;

    // Register reset values
    localparam logic [GROUP_CFG_W-1:0] WANTED_GROUP_RST = 14'd3;
    localparam logic [LOSS_CFG_W-1:0]  LOSS_LIMIT_RST   = 10'd90;

    // Output queue
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 2;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_PREFIX     = 4'd1,
        PH_SKIP       = 4'd2,
        PH_WAIT_ID    = 4'd3,
        PH_ID         = 4'd4,
        PH_WAIT_GROUP = 4'd5,
        PH_GROUP      = 4'd6,
        PH_WAIT_LOSS  = 4'd7,
        PH_LOSS       = 4'd8
    } phase_t;

    typedef enum logic [0:0] {
        CFG_WANTED_GROUP = 1'b0,
        CFG_LOSS_LIMIT   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [NUM_W-1:0] nearest_id;
        logic             any_found;
    } result_t;

endpackage

// ===== sv/beacon_scan_nearest_picker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_scan_nearest_picker
// Parses a beacon scan reply byte by byte and reports the nearest beacon of
// the wanted group on each end-of-scan byte.
// ----------------------------------------------------------------------------
// Takes one reply byte per clock cycle while in_stall is low. A byte is
// captured in an input register and parsed in the next cycle by a state
// update (a multiply-by-ten add and compares); an 'E' seen between records
// yields one result via the input register. Results wait in a three-entry
// queue, and in_stall rises only while that queue, together with the byte in
// flight, is full because the consumer stalls. Write wanted_group and
// loss_limit only while no scan byte is in flight.
module beacon_scan_nearest_picker #(
    parameter int PREFIX_LEN   = bsnp_pkg::PREFIX_LEN_DEF,
    parameter int ID_DIGITS    = bsnp_pkg::ID_DIGITS_DEF,
    parameter int GROUP_DIGITS = bsnp_pkg::GROUP_DIGITS_DEF,
    parameter int LOSS_DIGITS  = bsnp_pkg::LOSS_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bsnp_pkg::BYTE_W-1:0]     rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bsnp_pkg::NUM_W-1:0]      nearest_id,
    output logic                            any_found,
    input  logic                            cfg_we,
    input  bsnp_pkg::cfg_index_t            cfg_index,
    input  logic [bsnp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bsnp_pkg::*;

    logic                 stage_valid_reg;
    logic [BYTE_W-1:0]    stage_byte_reg;
    logic                 accept;
    logic                 res_valid;
    result_t              res;
    result_t              out_data;
    logic [OUT_CNT_W-1:0] q_count;
    logic [OUT_CNT_W:0]   pending;

    // Hold off input when the queue cannot take a result of every byte in flight
    assign pending  = {1'b0, q_count} + (OUT_CNT_W+1)'(stage_valid_reg);
    assign in_stall = (pending >= (OUT_CNT_W+1)'(OUT_DEPTH));
    assign accept   = in_valid && !in_stall;

    // Capture the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= rx_byte;
        end
    end

    bsnp_parser #(
        .PREFIX_LEN   (PREFIX_LEN),
        .ID_DIGITS    (ID_DIGITS),
        .GROUP_DIGITS (GROUP_DIGITS),
        .LOSS_DIGITS  (LOSS_DIGITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (stage_valid_reg),
        .rx_byte    (stage_byte_reg),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    bsnp_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .count     (q_count)
    );

    assign nearest_id = out_data.nearest_id;
    assign any_found  = out_data.any_found;

    a_room_for_stage: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> (q_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("byte in flight without queue room");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == OUT_CNT_W'(OUT_DEPTH)) |-> in_stall)
        else $error("input open while queue full");

endmodule

// ===== sv/bsnp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsnp_parser
// Byte-wise scan reply parser: walks the record phases, accumulates decimal
// fields, keeps the best record and emits one result on end of scan.
// ----------------------------------------------------------------------------
module bsnp_parser #(
    parameter int PREFIX_LEN   = bsnp_pkg::PREFIX_LEN_DEF,
    parameter int ID_DIGITS    = bsnp_pkg::ID_DIGITS_DEF,
    parameter int GROUP_DIGITS = bsnp_pkg::GROUP_DIGITS_DEF,
    parameter int LOSS_DIGITS  = bsnp_pkg::LOSS_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    input  logic [bsnp_pkg::BYTE_W-1:0]       rx_byte,
    input  logic                              cfg_we,
    input  bsnp_pkg::cfg_index_t              cfg_index,
    input  logic [bsnp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              res_valid,
    output bsnp_pkg::result_t                 res
);
    import bsnp_pkg::*;

    localparam logic [CNT_W-1:0] PREFIX_END = CNT_W'(PREFIX_LEN);
    localparam logic [CNT_W-1:0] ID_END     = CNT_W'(ID_DIGITS);
    localparam logic [CNT_W-1:0] GROUP_END  = CNT_W'(GROUP_DIGITS);
    localparam logic [CNT_W-1:0] LOSS_END   = CNT_W'(LOSS_DIGITS);

    phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [NUM_W-1:0]       acc_reg, acc_next;
    logic                   nonzero_reg, nonzero_next;
    logic [NUM_W-1:0]       cur_id_reg, cur_id_next;
    logic [NUM_W-1:0]       cur_group_reg, cur_group_next;
    logic [NUM_W-1:0]       best_id_reg, best_id_next;
    logic [NUM_W-1:0]       best_loss_reg, best_loss_next;
    logic                   found_reg, found_next;
    logic [GROUP_CFG_W-1:0] wanted_group_reg;
    logic [LOSS_CFG_W-1:0]  loss_limit_reg;

    logic [CNT_W-1:0]       cnt_inc;
    logic [NUM_W-1:0]       acc_step;
    logic                   nonzero_upd;
    logic                   keep;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_group_reg <= WANTED_GROUP_RST;
            loss_limit_reg   <= LOSS_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WANTED_GROUP: wanted_group_reg <= cfg_data[GROUP_CFG_W-1:0];
                CFG_LOSS_LIMIT:   loss_limit_reg   <= cfg_data[LOSS_CFG_W-1:0];
                default:          wanted_group_reg <= wanted_group_reg;
            endcase
        end
    end

    // Shared arithmetic: counter step, value*10 + digit, keep decision
    assign cnt_inc     = cnt_reg + 1'b1;
    assign acc_step    = (acc_reg << 3) + (acc_reg << 1) + NUM_W'(rx_byte) - NUM_W'(CH_ZERO);
    assign nonzero_upd = nonzero_reg | (rx_byte != CH_ZERO);
    assign keep        = (cur_group_reg == NUM_W'(wanted_group_reg))
                         && (acc_step <= NUM_W'(loss_limit_reg))
                         && (!found_reg || (acc_step < best_loss_reg));

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            nonzero_reg   <= 1'b0;
            cur_id_reg    <= '0;
            cur_group_reg <= '0;
            best_id_reg   <= '0;
            best_loss_reg <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            nonzero_reg   <= nonzero_next;
            cur_id_reg    <= cur_id_next;
            cur_group_reg <= cur_group_next;
            best_id_reg   <= best_id_next;
            best_loss_reg <= best_loss_next;
            found_reg     <= found_next;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        nonzero_next   = nonzero_reg;
        cur_id_next    = cur_id_reg;
        cur_group_next = cur_group_reg;
        best_id_next   = best_id_reg;
        best_loss_next = best_loss_reg;
        found_next     = found_reg;
        res_valid      = 1'b0;
        res.nearest_id = best_id_reg;
        res.any_found  = found_reg;

        if (byte_valid)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == CH_COLON)
                    begin
                        cnt_next     = '0;
                        nonzero_next = 1'b0;
                        phase_next   = PH_PREFIX;
                    end
                    else if (rx_byte == CH_END)
                    begin
                        res_valid  = 1'b1;
                        found_next = 1'b0;
                    end
                end
                PH_PREFIX:
                begin
                    nonzero_next = nonzero_upd;
                    cnt_next     = cnt_inc;
                    if (cnt_inc >= PREFIX_END)
                    begin
                        cnt_next   = '0;
                        phase_next = nonzero_upd ? PH_WAIT_ID : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (rx_byte == CH_COLON)
                    begin
                        cnt_next = cnt_inc;
                        if (cnt_inc >= SKIP_COLONS)
                        begin
                            cnt_next   = '0;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_WAIT_ID:
                begin
                    if (rx_byte == CH_COLON)
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_ID;
                    end
                end
                PH_ID:
                begin
                    acc_next = acc_step;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= ID_END)
                    begin
                        cur_id_next = acc_step;
                        phase_next  = PH_WAIT_GROUP;
                    end
                end
                PH_WAIT_GROUP:
                begin
                    if (rx_byte == CH_COLON)
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_GROUP;
                    end
                end
                PH_GROUP:
                begin
                    acc_next = acc_step;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= GROUP_END)
                    begin
                        cur_group_next = acc_step;
                        phase_next     = PH_WAIT_LOSS;
                    end
                end
                PH_WAIT_LOSS:
                begin
                    if (rx_byte == CH_DASH)
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_LOSS;
                    end
                end
                PH_LOSS:
                begin
                    acc_next = acc_step;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= LOSS_END)
                    begin
                        if (keep)
                        begin
                            best_id_next   = cur_id_reg;
                            best_loss_next = acc_step;
                            found_next     = 1'b1;
                        end
                        cnt_next   = '0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    // A result only leaves from idle, and it always clears the found flag
    a_res_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == PH_IDLE))
        else $error("result outside idle");

    a_res_clears_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !found_reg)
        else $error("found flag not cleared after result");

    a_found_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> (best_loss_reg <= NUM_W'($past(loss_limit_reg))))
        else $error("kept loss above limit");

endmodule

// ===== sv/bsnp_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsnp_out_queue
// Small result queue that decouples the parser from a stalling consumer.
// ----------------------------------------------------------------------------
module bsnp_out_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  bsnp_pkg::result_t              push_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bsnp_pkg::result_t              out_data,
    output logic [bsnp_pkg::OUT_CNT_W-1:0] count
);
    import bsnp_pkg::*;

    localparam logic [OUT_PTR_W-1:0] PTR_LAST = OUT_PTR_W'(OUT_DEPTH - 1);

    result_t                slot_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != OUT_CNT_W'(OUT_DEPTH)) || pop)
        else $error("push into full queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("queue count out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("pop did not drain queue");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of beacon_scan_nearest_picker.
// Streams beacon scan replies one byte per transaction: hand-picked records,
// register sweeps, random record streams with noise and broken records, and
// long result back-pressure. A parser model inside the bench predicts each
// end-of-scan report, and a checker compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
    import bsnp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FLUSH_CYCLES = 4;
    localparam int LONG_HOLD    = 200;
    localparam int RANDOM_BYTES = 1550;
    localparam int TOTAL_BYTES  = 1700;
    localparam int MAX_REPORTED = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     rx_byte   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [NUM_W-1:0]      nearest_id;
    logic                  any_found;
    logic                  cfg_we    = 1'b0;
    cfg_index_t            cfg_index = CFG_WANTED_GROUP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Parser model state and its copy of the registers
    phase_t                 scan_phase     = PH_IDLE;
    logic [CNT_W-1:0]       scan_count     = '0;
    logic [NUM_W-1:0]       scan_acc       = '0;
    logic                   prefix_nonzero = 1'b0;
    logic [NUM_W-1:0]       scan_id        = '0;
    logic [NUM_W-1:0]       scan_group     = '0;
    logic [NUM_W-1:0]       best_id        = '0;
    logic [NUM_W-1:0]       best_loss      = '0;
    logic                   scan_found     = 1'b0;
    logic [GROUP_CFG_W-1:0] wanted_group   = WANTED_GROUP_RST;
    logic [LOSS_CFG_W-1:0]  loss_limit     = LOSS_LIMIT_RST;

    result_t expected_reports[$];
    int      bytes_accepted   = 0;
    int      mismatch_count   = 0;
    int      sender_quiet     = 0;
    bit      sender_idling    = 1'b1;
    bit      receiver_idling  = 1'b1;
    bit      hold_request     = 1'b0;

    beacon_scan_nearest_picker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .nearest_id (nearest_id),
        .any_found  (any_found),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    function automatic void begin_number(input phase_t target);
        scan_acc   = '0;
        scan_count = '0;
        scan_phase = target;
    endfunction

    // Fold one byte into the number; digits are taken as they come, unchecked
    function automatic bit add_digit(input logic [BYTE_W-1:0] ch, input int count);
        scan_acc   = scan_acc * 16'd10 + {8'd0, ch} - {8'd0, CH_ZERO};
        scan_count = scan_count + 4'd1;
        return int'(scan_count) >= count;
    endfunction

    task automatic parse_reply_byte(input logic [BYTE_W-1:0] ch);
        result_t report;
        case (scan_phase)
            PH_IDLE:
            begin
                if (ch == CH_COLON)
                begin
                    scan_count     = '0;
                    prefix_nonzero = 1'b0;
                    scan_phase     = PH_PREFIX;
                end
                else if (ch == CH_END)
                begin
                    // Report the scan, then forget that anything was found
                    report.nearest_id = best_id;
                    report.any_found  = scan_found;
                    expected_reports.push_back(report);
                    scan_found = 1'b0;
                end
            end
            PH_PREFIX:
            begin
                if (ch != CH_ZERO)
                    prefix_nonzero = 1'b1;
                scan_count = scan_count + 4'd1;
                if (int'(scan_count) >= PREFIX_LEN_DEF)
                begin
                    scan_count = '0;
                    if (prefix_nonzero)
                        scan_phase = PH_WAIT_ID;
                    else
                        scan_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (ch == CH_COLON)
                begin
                    scan_count = scan_count + 4'd1;
                    if (scan_count >= SKIP_COLONS)
                    begin
                        scan_count = '0;
                        scan_phase = PH_IDLE;
                    end
                end
            end
            PH_WAIT_ID:
            begin
                if (ch == CH_COLON)
                    begin_number(PH_ID);
            end
            PH_ID:
            begin
                if (add_digit(ch, ID_DIGITS_DEF))
                begin
                    scan_id    = scan_acc;
                    scan_phase = PH_WAIT_GROUP;
                end
            end
            PH_WAIT_GROUP:
            begin
                if (ch == CH_COLON)
                    begin_number(PH_GROUP);
            end
            PH_GROUP:
            begin
                if (add_digit(ch, GROUP_DIGITS_DEF))
                begin
                    scan_group = scan_acc;
                    scan_phase = PH_WAIT_LOSS;
                end
            end
            PH_WAIT_LOSS:
            begin
                if (ch == CH_DASH)
                    begin_number(PH_LOSS);
            end
            PH_LOSS:
            begin
                if (add_digit(ch, LOSS_DIGITS_DEF))
                begin
                    // Keep the record if it is in the group, in range and nearer
                    if (scan_group == {2'b00, wanted_group} &&
                        scan_acc <= {6'b000000, loss_limit} &&
                        (!scan_found || scan_acc < best_loss))
                    begin
                        best_id    = scan_id;
                        best_loss  = scan_acc;
                        scan_found = 1'b1;
                    end
                    scan_count = '0;
                    scan_phase = PH_IDLE;
                end
            end
            default:
            begin
                scan_phase = PH_IDLE;
                scan_count = '0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    function automatic void note_mismatch(input string field, input logic [NUM_W-1:0] want,
                                          input logic [NUM_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("[%0t] mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    always @(posedge clk)
    begin : check_reports
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
                note_mismatch("unexpected transaction, nearest_id", '0, nearest_id);
            else
            begin
                want = expected_reports.pop_front();
                if (nearest_id !== want.nearest_id)
                    note_mismatch("nearest_id", want.nearest_id, nearest_id);
                if (any_found !== want.any_found)
                    note_mismatch("any_found", NUM_W'(want.any_found), NUM_W'(any_found));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Consumer: random stall bursts, quiet stretches and one long hold-off
    // ------------------------------------------------------------------------

    initial
    begin : receiver
        int quiet;
        int hold_cycles;
        quiet = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // Hold off long enough for the result queue to fill
                out_stall <= 1'b1;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (!receiver_idling || quiet > 0)
            begin
                out_stall <= 1'b0;
                if (quiet > 0)
                    quiet--;
            end
            else if ($urandom_range(0, 31) == 0)
            begin
                out_stall <= 1'b0;
                quiet = $urandom_range(20, 60);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one byte, with an occasional idle burst first, and wait for it to be taken
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        @(negedge clk);
        gap = 0;
        if (sender_quiet > 0)
            sender_quiet--;
        else if (sender_idling)
        begin
            if ($urandom_range(0, 47) == 0)
                sender_quiet = $urandom_range(16, 48);
            else if ($urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 8);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_reply_byte(value);
        bytes_accepted++;
    endtask

    // Drop valid, let every expected report arrive, then let the pipeline settle
    task automatic wait_until_reported();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t index, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_WANTED_GROUP)
            wanted_group = value[GROUP_CFG_W-1:0];
        else
            loss_limit = value[LOSS_CFG_W-1:0];
    endtask

    task automatic set_registers(input int group, input int limit);
        write_register(CFG_WANTED_GROUP, CFG_DATA_W'(group));
        write_register(CFG_LOSS_LIMIT, CFG_DATA_W'(limit));
    endtask

    // Send a zero-padded decimal number, optionally with some bytes garbled
    task automatic send_number(input int value, input int digits, input bit garble);
        int                scale;
        logic [BYTE_W-1:0] ch;
        scale = 1;
        repeat (digits - 1) scale *= 10;
        while (scale > 0)
        begin
            ch = CH_ZERO + BYTE_W'((value / scale) % 10);
            if (garble && $urandom_range(0, 3) == 0)
                ch = BYTE_W'($urandom_range(0, 255));
            send_byte(ch);
            scale /= 10;
        end
    endtask

    // Send bytes other than the awaited separator; an end byte shows up often
    task automatic send_filler(input logic [BYTE_W-1:0] awaited, input int count);
        logic [BYTE_W-1:0] ch;
        repeat (count)
        begin
            do
            begin
                if ($urandom_range(0, 3) == 0)
                    ch = CH_END;
                else
                    ch = BYTE_W'($urandom_range(0, 255));
            end
            while (ch == awaited);
            send_byte(ch);
        end
    endtask

    task automatic send_record(input int id, input int group, input int loss,
                               input bit zero_prefix, input int filler, input bit garble);
        int                i;
        int                odd_pos;
        logic [BYTE_W-1:0] ch;
        send_byte(CH_COLON);
        odd_pos = $urandom_range(0, PREFIX_LEN_DEF - 1);
        for (i = 0; i < PREFIX_LEN_DEF; i++)
        begin
            if (zero_prefix || (i != odd_pos && $urandom_range(0, 1) == 0))
                ch = CH_ZERO;
            else
            begin
                do
                    ch = BYTE_W'($urandom_range(0, 255));
                while (i == odd_pos && ch == CH_ZERO);
            end
            send_byte(ch);
        end
        if (zero_prefix)
        begin
            // Pass over the rest of an ignored record
            repeat (SKIP_COLONS)
            begin
                send_filler(CH_COLON, $urandom_range(0, filler));
                send_byte(CH_COLON);
            end
        end
        else
        begin
            send_filler(CH_COLON, $urandom_range(0, filler));
            send_byte(CH_COLON);
            send_number(id, ID_DIGITS_DEF, garble);
            send_filler(CH_COLON, $urandom_range(0, filler));
            send_byte(CH_COLON);
            send_number(group, GROUP_DIGITS_DEF, garble);
            send_filler(CH_DASH, $urandom_range(0, filler));
            send_byte(CH_DASH);
            send_number(loss, LOSS_DIGITS_DEF, garble);
        end
    endtask

    function automatic int pick_id();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 999;
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    function automatic int pick_group();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 9999);
            1: return (wanted_group == 0) ? 1 : int'(wanted_group) - 1;
            default: return int'(wanted_group);
        endcase
    endfunction

    // Favor losses around the limit and around the best loss so far
    function automatic int pick_loss();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 999);
            1: v = int'(best_loss) + int'($urandom_range(0, 2)) - 1;
            default: v = int'(loss_limit) + int'($urandom_range(0, 6)) - 3;
        endcase
        if (v < 0)
            v = 0;
        if (v > 999)
            v = 999;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Report straight after reset; stray bytes between records do nothing
    task automatic test_reset_report();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(CH_END);
        wait_until_reported();
    endtask

    // Keep rules under the reset registers: group 3, loss limit 90
    task automatic test_record_rules();
        send_record(123, 3, 50, 1'b0, 2, 1'b0);
        send_byte(CH_END);
        send_byte(CH_END);
        send_record(7, 3, 90, 1'b0, 1, 1'b0);
        send_record(8, 3, 90, 1'b0, 1, 1'b0);
        send_record(9, 4, 10, 1'b0, 1, 1'b0);
        send_record(10, 3, 91, 1'b0, 1, 1'b0);
        send_record(11, 3, 89, 1'b0, 2, 1'b0);
        send_record(12, 3, 0, 1'b1, 2, 1'b0);
        send_record(999, 3, 0, 1'b0, 0, 1'b1);
        send_record(0, 9999, 0, 1'b0, 3, 1'b0);
        send_byte(CH_END);
        wait_until_reported();
    endtask

    // Sweep register settings, extremes first
    task automatic test_register_settings();
        int k;
        for (k = 0; k < 6; k++)
        begin
            case (k)
                0: set_registers(0, 0);
                1: set_registers(9999, 999);
                2: set_registers(0, 999);
                3: set_registers(9999, 0);
                default: set_registers($urandom_range(0, 9999), $urandom_range(0, 999));
            endcase
            repeat (6)
                send_record(pick_id(), pick_group(), pick_loss(), $urandom_range(0, 7) == 0,
                            2, 1'b0);
            send_byte(CH_END);
            wait_until_reported();
        end
    endtask

    // Mostly well-formed scans, with noise, broken records and reconfiguration
    task automatic test_random_scans();
        int next_reconfig;
        next_reconfig = bytes_accepted + 200;
        while (bytes_accepted < RANDOM_BYTES)
        begin
            if (bytes_accepted >= next_reconfig)
            begin
                wait_until_reported();
                set_registers($urandom_range(0, 9999), $urandom_range(0, 999));
                next_reconfig = bytes_accepted + 200;
            end
            case ($urandom_range(0, 19))
                0, 1, 2: send_byte(CH_END);
                3:
                begin
                    repeat ($urandom_range(1, 6))
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                4:
                begin
                    // Abandon a record part way through
                    send_byte(CH_COLON);
                    repeat ($urandom_range(0, 12))
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                default:
                    send_record(pick_id(), pick_group(), pick_loss(), $urandom_range(0, 9) == 0,
                                $urandom_range(0, 3), $urandom_range(0, 19) == 0);
            endcase
        end
        wait_until_reported();
    endtask

    // Keep offering end bytes while the consumer holds off, so the input stalls
    task automatic test_result_backpressure();
        sender_idling = 1'b0;
        send_record(pick_id(), int'(wanted_group), 0, 1'b0, 0, 1'b0);
        hold_request = 1'b1;
        repeat (12) send_byte(CH_END);
        while (hold_request)
            @(posedge clk);
        sender_idling = 1'b1;
        wait_until_reported();
    endtask

    // Finish with back-to-back traffic and no idling on either side
    task automatic test_steady_stream();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        while (bytes_accepted < TOTAL_BYTES)
        begin
            send_record(pick_id(), pick_group(), pick_loss(), 1'b0, 0, 1'b0);
            if ($urandom_range(0, 2) == 0)
                send_byte(CH_END);
        end
        send_byte(CH_END);
        wait_until_reported();
    endtask

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("beacon_scan_nearest_picker verification failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_report();
        test_record_rules();
        test_register_settings();
        test_random_scans();
        test_result_backpressure();
        test_steady_stream();

        // Give a stray result time to show up
        repeat (4 * FLUSH_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("beacon_scan_nearest_picker verification clean");
        else
            $display("beacon_scan_nearest_picker verification failed");
        $finish;
    end

endmodule
